[hw/rtl/rim_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rim_pkg
// Shared types and codes of the region interval map.
// ----------------------------------------------------------------------------
package rim_pkg;

    // One table entry: base, byte length, protection word
    typedef struct packed {
        logic [31:0] attr;
        logic [31:0] len;
        logic [31:0] base;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FRD,
        S_FPROC,
        S_MST,
        S_MOD,
        S_SRD,
        S_SPROC,
        S_SCOMP,
        S_PRD,
        S_PSET,
        S_CRD,
        S_CPROC,
        S_CEMIT2,
        S_CEND,
        S_FIN,
        S_OUT
    } t_state;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ALIGN = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_FIND   = 1'b1;

    localparam int OUT_BITS = 112;

endpackage

[hw/rtl/rim_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rim_ram
// Simple dual-port table bank: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rim_ram #(
    parameter int DEPTH = 66,
    parameter int WIDTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hw/rtl/rim_mod_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rim_mod_unit
// Page-size alignment check of a 32-bit length by reciprocal multiplication.
// ----------------------------------------------------------------------------
// A start loads the length into a register. The quotient by the page size is
// then registered, formed with a rounded-up reciprocal, which is exact for every
// 32-bit length. The quotient is then multiplied back and compared with the
// length. Done pulses with the registered remainder flag, and the flag holds
// until the next check.
module rim_mod_unit #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_value,
    output logic        o_done,
    output logic        o_rem_nz
);

    localparam int SH = $clog2(PAGE_BYTES);
    localparam logic [63:0] RECIP64 =
        ((64'd1 << (32 + SH)) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
    localparam logic [32:0] RECIP = RECIP64[32:0];
    localparam logic [16:0] PG    = 17'(PAGE_BYTES);

    logic        r_mul;
    logic        r_chk;
    logic        r_done;
    logic [31:0] r_val;
    logic [31:0] r_quo;
    logic        r_nz;
    logic [64:0] w_prod;
    logic [64:0] w_quo;
    logic [48:0] w_back;

    // Quotient by reciprocal, then multiply back
    always_comb begin
        w_prod = 65'(r_val) * 65'(RECIP);
        w_quo  = w_prod >> (32 + SH);
        w_back = 49'(r_quo) * 49'(PG);
    end

    // Step the sequence: multiply, check, done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_chk  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_mul  <= i_start;
            r_chk  <= r_mul;
            r_done <= r_chk;
        end
    end

    // Advance the datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
        end
        if (r_mul) begin
            r_quo <= w_quo[31:0];
        end
        if (r_chk) begin
            r_nz <= (w_back != 49'(r_val));
        end
    end

    assign o_done   = r_done;
    assign o_rem_nz = r_nz;

endmodule

[hw/rtl/region_interval_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_interval_map
// Sorted region table with insert (split, trim, merge) and find-at-or-below.
// ----------------------------------------------------------------------------
// The block holds one item at a time. A find scans the table entry by entry.
// An insert runs one or two rebuild passes (the second only when a covering
// region is split and leaves a tail); each pass runs a page-size check by
// reciprocal multiplication, a scan of the source table and a copy into a
// spare table bank, with an extra write where the new entry lands ahead of
// a kept entry. Three table banks rotate so that a full-table insert is
// dropped simply by keeping the old bank. The rate is set by the single read
// port of the table banks. No clearing pass is needed after reset.
module region_interval_map #(
    parameter int MAX_REGIONS = 64,
    parameter int PAGE_BYTES  = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // tdata: region_start[31:0], region_bytes[63:32], protection[95:64],
    //        query_address[127:96]
    input  logic [127:0]                 i_s_tdata,
    // tuser: kind[0]
    input  logic                         i_s_tuser,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // tdata: status[1:0], found[2], hit_start[34:3], hit_bytes[66:35],
    //        hit_protection[98:67], occupancy[105:99], zero fill[111:106]
    output logic [rim_pkg::OUT_BITS-1:0] o_m_tdata
);

    localparam int DEPTH = MAX_REGIONS + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EW    = $bits(rim_pkg::t_entry);

    rim_pkg::t_state r_state, n_state;

    logic [31:0] r_b, n_b, r_l, n_l, r_a, n_a, r_q, n_q;
    logic        r_pass, n_pass;
    logic [1:0]  r_src, n_src, r_dst, n_dst, r_cur, n_cur, r_fin_bank, n_fin_bank;
    logic [CW-1:0] r_n, n_n, r_sn, n_sn, r_k, n_k, r_w, n_w;
    logic [CW-1:0] r_ie, n_ie, r_k1, n_k1, r_k2, n_k2, r_ce, n_ce, r_pe, n_pe;
    logic [CW-1:0] r_fin_n, n_fin_n, r_rs_occ, n_rs_occ;
    logic        r_ie_vld, n_ie_vld, r_k1_vld, n_k1_vld, r_k2_vld, n_k2_vld;
    logic [31:0] r_ie_len, n_ie_len;
    logic        r_inplace, n_inplace, r_have_p, n_have_p, r_p_drop, n_p_drop;
    logic        r_alive, n_alive, r_c_done, n_c_done, r_tail_vld, n_tail_vld;
    rim_pkg::t_entry r_pnew, n_pnew, r_cent, n_cent, r_hold, n_hold;
    rim_pkg::t_entry r_tail, n_tail, r_prev, n_prev, r_rs_hit, n_rs_hit;
    logic [1:0]  r_rs_status, n_rs_status;
    logic        r_rs_found, n_rs_found;
    logic        r_o_valid, n_o_valid;
    logic [rim_pkg::OUT_BITS-1:0] r_o_data, n_o_data;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    rim_pkg::t_entry ram_wdata, rd;
    logic [EW-1:0]   bank_rdata [3];
    logic            mod_start, mod_done, mod_nz;

    // Three rotating table banks
    for (genvar g = 0; g < 3; g++) begin : g_bank
        rim_ram #(
            .DEPTH (DEPTH),
            .WIDTH (EW)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we && (r_dst == 2'(g))),
            .i_waddr (ram_waddr),
            .i_wdata (ram_wdata),
            .i_raddr (ram_raddr),
            .o_rdata (bank_rdata[g])
        );
    end

    rim_mod_unit #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mod_start),
        .i_value  (r_l),
        .o_done   (mod_done),
        .o_rem_nz (mod_nz)
    );

    assign rd        = (r_src == 2'd0) ? bank_rdata[0] :
                       (r_src == 2'd1) ? bank_rdata[1] : bank_rdata[2];
    assign mod_start = (r_state == rim_pkg::S_MST);
    assign o_s_tready = (r_state == rim_pkg::S_IDLE);
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

    function automatic logic [1:0] f_next_bank(input logic [1:0] x);
        f_next_bank = (x == 2'd2) ? 2'd0 : x + 2'd1;
    endfunction

    // Sequencer: next state, table access and working registers
    always_comb begin
        logic [31:0]   cend, dend, pend;
        logic [CW-1:0] ce, cl, wtot;
        logic [31:0]   occ32;
        logic          emit2;

        n_state = r_state;
        n_b = r_b; n_l = r_l; n_a = r_a; n_q = r_q;
        n_pass = r_pass; n_src = r_src; n_dst = r_dst; n_cur = r_cur;
        n_fin_bank = r_fin_bank; n_n = r_n; n_sn = r_sn; n_k = r_k; n_w = r_w;
        n_ie = r_ie; n_k1 = r_k1; n_k2 = r_k2; n_ce = r_ce; n_pe = r_pe;
        n_fin_n = r_fin_n; n_rs_occ = r_rs_occ;
        n_ie_vld = r_ie_vld; n_k1_vld = r_k1_vld; n_k2_vld = r_k2_vld;
        n_ie_len = r_ie_len; n_inplace = r_inplace; n_have_p = r_have_p;
        n_p_drop = r_p_drop; n_alive = r_alive; n_c_done = r_c_done;
        n_tail_vld = r_tail_vld; n_pnew = r_pnew; n_cent = r_cent;
        n_hold = r_hold; n_tail = r_tail; n_prev = r_prev; n_rs_hit = r_rs_hit;
        n_rs_status = r_rs_status; n_rs_found = r_rs_found;
        n_o_valid = r_o_valid; n_o_data = r_o_data;

        ram_we    = 1'b0;
        ram_waddr = r_w[AW-1:0];
        ram_wdata = rd;
        ram_raddr = r_k[AW-1:0];

        cend  = r_b + r_l;
        dend  = rd.base + rd.len;
        pend  = rd.base + rd.len;
        ce    = '0;
        cl    = '0;
        wtot  = r_w;
        occ32 = '0;
        emit2 = 1'b0;

        // Drop the output once the downstream side takes it
        if (r_o_valid && i_m_tready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            rim_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_b = i_s_tdata[31:0];
                    n_l = i_s_tdata[63:32];
                    n_a = i_s_tdata[95:64];
                    n_q = i_s_tdata[127:96];
                    n_pass = 1'b0;
                    n_src = r_cur;
                    n_dst = f_next_bank(r_cur);
                    n_sn = r_n;
                    n_k = '0;
                    n_rs_status = rim_pkg::ST_OK;
                    n_rs_found = 1'b0;
                    n_rs_hit = '0;
                    n_state = (i_s_tuser == rim_pkg::KIND_FIND) ? rim_pkg::S_FRD
                                                                : rim_pkg::S_MST;
                end
            end
            // Find: keep the last entry whose base is at or below the address
            rim_pkg::S_FRD: begin
                if (r_k == r_sn) begin
                    n_rs_found = (r_k != '0);
                    n_rs_hit = (r_k != '0) ? r_prev : '0;
                    n_rs_occ = r_n;
                    n_state = rim_pkg::S_OUT;
                end else begin
                    n_state = rim_pkg::S_FPROC;
                end
            end
            rim_pkg::S_FPROC: begin
                if (r_q < rd.base) begin
                    n_rs_found = (r_k != '0);
                    n_rs_hit = (r_k != '0) ? r_prev : '0;
                    n_rs_occ = r_n;
                    n_state = rim_pkg::S_OUT;
                end else begin
                    n_prev = rd;
                    n_k = r_k + CW'(1);
                    n_state = rim_pkg::S_FRD;
                end
            end
            rim_pkg::S_MST: begin
                n_state = rim_pkg::S_MOD;
            end
            rim_pkg::S_MOD: begin
                if (mod_done) begin
                    if (mod_nz) begin
                        if (!r_pass) begin
                            n_rs_status = rim_pkg::ST_ALIGN;
                            n_rs_occ = r_n;
                            n_state = rim_pkg::S_OUT;
                        end else begin
                            n_state = rim_pkg::S_FIN;
                        end
                    end else begin
                        n_k = '0;
                        n_ie_vld = 1'b0;
                        n_k1_vld = 1'b0;
                        n_k2_vld = 1'b0;
                        n_state = rim_pkg::S_SRD;
                    end
                end
            end
            // Scan: equal base, first and second entry at or above the base
            rim_pkg::S_SRD: begin
                n_state = (r_k == r_sn) ? rim_pkg::S_SCOMP : rim_pkg::S_SPROC;
            end
            rim_pkg::S_SPROC: begin
                if (!r_ie_vld && (rd.base == r_b)) begin
                    n_ie_vld = 1'b1;
                    n_ie = r_k;
                    n_ie_len = rd.len;
                end
                if (rd.base >= r_b) begin
                    if (!r_k1_vld) begin
                        n_k1_vld = 1'b1;
                        n_k1 = r_k;
                    end else if (!r_k2_vld) begin
                        n_k2_vld = 1'b1;
                        n_k2 = r_k;
                    end
                end
                n_k = r_k + CW'(1);
                n_state = rim_pkg::S_SRD;
            end
            // Place the new entry and locate the entry before it
            rim_pkg::S_SCOMP: begin
                if (!r_k1_vld) begin
                    ce = r_sn;
                end else if (r_ie_vld && (r_k1 == r_ie)) begin
                    ce = r_k2_vld ? r_k2 : r_sn;
                end else begin
                    ce = r_k1;
                end
                cl = ce - ((r_ie_vld && (r_ie < ce)) ? CW'(1) : CW'(0));
                n_ce = ce;
                n_pe = (r_ie_vld && ((ce - CW'(1)) == r_ie)) ? ce - CW'(2) : ce - CW'(1);
                n_inplace = r_ie_vld && (r_ie_len >= r_l);
                n_have_p = (cl != '0);
                n_p_drop = 1'b0;
                n_alive = 1'b1;
                n_tail_vld = 1'b0;
                n_cent = '{attr: r_a, len: r_l, base: r_b};
                n_c_done = 1'b0;
                n_k = '0;
                n_w = '0;
                n_state = ((cl != '0) && !(r_ie_vld && (r_ie_len >= r_l))) ?
                          rim_pkg::S_PRD : rim_pkg::S_CRD;
            end
            rim_pkg::S_PRD: begin
                ram_raddr = r_pe[AW-1:0];
                n_state = rim_pkg::S_PSET;
            end
            // Split, trim or merge with the entry before
            rim_pkg::S_PSET: begin
                n_pnew = rd;
                if (pend >= cend) begin
                    if (rd.attr == r_a) begin
                        n_alive = 1'b0;
                    end else begin
                        n_tail = '{attr: rd.attr, len: pend - cend, base: cend};
                        n_tail_vld = (pend != cend);
                        n_pnew.len = r_b - rd.base;
                    end
                end else if (pend >= r_b) begin
                    if (rd.attr == r_a) begin
                        n_p_drop = 1'b1;
                        n_cent = '{attr: r_a, len: cend - rd.base, base: rd.base};
                    end else begin
                        n_pnew.len = r_b - rd.base;
                    end
                end
                n_state = rim_pkg::S_CRD;
            end
            // Copy into the spare bank, editing on the way
            rim_pkg::S_CRD: begin
                n_state = (r_k == r_sn) ? rim_pkg::S_CEND : rim_pkg::S_CPROC;
            end
            rim_pkg::S_CPROC: begin
                if (r_inplace) begin
                    ram_we = 1'b1;
                    if (r_k == r_ie) begin
                        ram_wdata = '{attr: r_a, len: r_l, base: rd.base};
                    end
                end else if (r_ie_vld && (r_k == r_ie)) begin
                    ram_we = 1'b0;
                end else if (r_k < r_ce) begin
                    if (r_have_p && (r_k == r_pe)) begin
                        ram_we = !r_p_drop;
                        ram_wdata = r_pnew;
                    end else begin
                        ram_we = 1'b1;
                    end
                end else if (!r_alive || r_c_done) begin
                    ram_we = 1'b1;
                end else if (cend < rd.base) begin
                    ram_we = 1'b1;
                    ram_wdata = r_cent;
                    n_hold = rd;
                    emit2 = 1'b1;
                    n_c_done = 1'b1;
                end else if (cend >= dend) begin
                    ram_we = 1'b0;
                end else if (rd.attr == r_a) begin
                    ram_we = 1'b1;
                    ram_wdata = '{attr: r_cent.attr, len: dend - r_cent.base,
                                  base: r_cent.base};
                    n_c_done = 1'b1;
                end else begin
                    ram_we = 1'b1;
                    ram_wdata = r_cent;
                    n_hold = '{attr: rd.attr, len: dend - cend, base: cend};
                    emit2 = 1'b1;
                    n_c_done = 1'b1;
                end
                n_w = r_w + (ram_we ? CW'(1) : CW'(0));
                n_k = r_k + CW'(1);
                n_state = emit2 ? rim_pkg::S_CEMIT2 : rim_pkg::S_CRD;
            end
            rim_pkg::S_CEMIT2: begin
                ram_we = 1'b1;
                ram_wdata = r_hold;
                n_w = r_w + CW'(1);
                n_state = rim_pkg::S_CRD;
            end
            // Append the new entry if still pending, then the tail pass
            rim_pkg::S_CEND: begin
                if (!r_inplace && r_alive && !r_c_done) begin
                    ram_we = 1'b1;
                    ram_wdata = r_cent;
                end
                wtot = r_w + (ram_we ? CW'(1) : CW'(0));
                n_fin_bank = r_dst;
                n_fin_n = wtot;
                if (!r_pass && r_tail_vld && !r_inplace) begin
                    n_b = r_tail.base;
                    n_l = r_tail.len;
                    n_a = r_tail.attr;
                    n_pass = 1'b1;
                    n_src = r_dst;
                    n_dst = f_next_bank(r_dst);
                    n_sn = wtot;
                    n_state = rim_pkg::S_MST;
                end else begin
                    n_state = rim_pkg::S_FIN;
                end
            end
            // Commit the rebuilt bank unless it overflows
            rim_pkg::S_FIN: begin
                if (r_fin_n > CW'(MAX_REGIONS)) begin
                    n_rs_status = rim_pkg::ST_FULL;
                    n_rs_occ = r_n;
                end else begin
                    n_cur = r_fin_bank;
                    n_n = r_fin_n;
                    n_rs_occ = r_fin_n;
                end
                n_state = rim_pkg::S_OUT;
            end
            // Hold the result until the output register is free
            rim_pkg::S_OUT: begin
                if (!r_o_valid || i_m_tready) begin
                    occ32 = 32'(r_rs_occ);
                    n_o_valid = 1'b1;
                    n_o_data = {6'd0, occ32[6:0], r_rs_hit.attr, r_rs_hit.len,
                                r_rs_hit.base, r_rs_found, r_rs_status};
                    n_state = rim_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rim_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rim_pkg::S_IDLE;
            r_o_valid <= 1'b0;
            r_cur     <= 2'd0;
            r_n       <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_cur     <= n_cur;
            r_n       <= n_n;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_b <= n_b; r_l <= n_l; r_a <= n_a; r_q <= n_q;
        r_pass <= n_pass; r_src <= n_src; r_dst <= n_dst; r_fin_bank <= n_fin_bank;
        r_sn <= n_sn; r_k <= n_k; r_w <= n_w;
        r_ie <= n_ie; r_k1 <= n_k1; r_k2 <= n_k2; r_ce <= n_ce; r_pe <= n_pe;
        r_fin_n <= n_fin_n; r_rs_occ <= n_rs_occ;
        r_ie_vld <= n_ie_vld; r_k1_vld <= n_k1_vld; r_k2_vld <= n_k2_vld;
        r_ie_len <= n_ie_len; r_inplace <= n_inplace; r_have_p <= n_have_p;
        r_p_drop <= n_p_drop; r_alive <= n_alive; r_c_done <= n_c_done;
        r_tail_vld <= n_tail_vld; r_pnew <= n_pnew; r_cent <= n_cent;
        r_hold <= n_hold; r_tail <= n_tail; r_prev <= n_prev; r_rs_hit <= n_rs_hit;
        r_rs_status <= n_rs_status; r_rs_found <= n_rs_found;
        r_o_data <= n_o_data;
    end

endmodule

[hw/rtl/rim_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rim_checker
// Port-level checks of the region interval map, bound to the top level.
// ----------------------------------------------------------------------------
module rim_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [111:0] o_m_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed while stalled");

    // One item in work at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while an item is in work");

    // A hit comes only with status ok
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[2]) |-> (o_m_tdata[1:0] == 2'd0))
        else $error("hit with error status");

    // A miss carries zero hit fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[2]) |-> (o_m_tdata[98:3] == '0))
        else $error("miss with nonzero hit fields");

endmodule

bind region_interval_map rim_checker u_rim_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
